// ===== rtl/afc_pkg.sv =====
// Shared types, codes and constants of the animated frame compositor.
package afc_pkg;

    localparam int MAX_SIDE_DEF = 256;
    localparam int CMP_W        = 11;
    localparam int POS_W        = 8;
    localparam int SIZE_W       = 9;
    localparam int CRD_W        = 10;
    localparam int PIX_W        = 32;
    localparam int ACT_W        = 3;
    localparam int DM_W         = 2;
    localparam int TAKEN_W      = 18;
    localparam int IN_TDATA_W   = 72;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_SIDE_RST = 256;
    localparam int ALPHA_MAX    = 255;
    localparam int ALPHA_DIV    = 510;
    localparam int LANES        = 4;
    localparam int REM_W        = 25;
    localparam int DV_W         = 17;
    localparam int DIV_LAST     = 9;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BEGIN = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PIXEL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_END   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

    localparam logic [DM_W-1:0] DISP_CLEAR   = 2'd1;
    localparam logic [DM_W-1:0] DISP_RESTORE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_PX_RD,
        ST_PX_LOG,
        ST_PX_BLEND,
        ST_PX_WR,
        ST_RD_RD,
        ST_RD_OUT,
        ST_DCLR,
        ST_RS_RD,
        ST_RS_WR
    } t_state;

    typedef struct packed {
        logic ready;
        logic begin_frame;
        logic px_read;
        logic px_log;
        logic px_write;
        logic px_skip;
        logic rd_read;
        logic out_load;
        logic clr_step;
        logic dc_step;
        logic rs_read;
        logic rs_write;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic             in_valid;
        logic [ACT_W-1:0] act;
        logic [DM_W-1:0]  dispose;
        logic             blend;
        logic             px_take;
        logic             px_in;
        logic             clr_last;
        logic             dc_done;
        logic             rs_done;
        logic             blend_busy;
        logic             out_full;
    } t_sts;

endpackage

// ===== rtl/afc_blend.sv =====
// Source-over blend unit: staged products and a four-lane iterative divider.
module afc_blend import afc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PIX_W-1:0] i_src,
    input  logic [PIX_W-1:0] i_dst,
    output logic             o_busy,
    output logic [PIX_W-1:0] o_result
);

    logic             r_busy;
    logic [3:0]       r_stage;
    logic [PIX_W-1:0] r_src;
    logic [PIX_W-1:0] r_dst;
    logic [15:0]      r_w;
    logic [15:0]      r_den;
    logic [15:0]      r_sa [3];
    logic [REM_W-1:0] r_rem [LANES];
    logic [DV_W-1:0]  r_dv [LANES];
    logic [7:0]       r_q [LANES];
    logic             r_zero;

    logic [7:0]       a;
    logic [7:0]       d;
    logic [15:0]      p1_w;
    logic [2:0]       bit_i;
    logic [REM_W-1:0] shifted [LANES];
    logic             ge [LANES];
    logic [23:0]      num [3];

    assign a     = r_src[31:24];
    assign d     = r_dst[31:24];
    assign p1_w  = 16'(d) * 16'(8'(ALPHA_MAX) - a);
    assign bit_i = 3'(4'(DIV_LAST) - r_stage);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            shifted[l] = REM_W'(r_dv[l]) << bit_i;
            ge[l]      = r_rem[l] >= shifted[l];
        end
        for (int c = 0; c < 3; c++) begin
            num[c] = 24'({r_sa[c], 8'b0}) - 24'(r_sa[c])
                   + 24'(r_dst[8*c +: 8]) * 24'(r_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_stage <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_stage <= '0;
        end else if (r_busy) begin
            if (r_stage == 4'(DIV_LAST)) begin
                r_busy <= 1'b0;
            end
            r_stage <= r_stage + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_src;
            r_dst <= i_dst;
        end else if (r_busy) begin
            case (r_stage)
                4'd0: begin
                    r_w   <= p1_w;
                    r_den <= 16'({a, 8'b0}) - 16'(a) + p1_w;
                    for (int c = 0; c < 3; c++) begin
                        r_sa[c] <= 16'(r_src[8*c +: 8]) * 16'(a);
                    end
                end
                4'd1: begin
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= REM_W'({num[c], 1'b0}) + REM_W'(r_den);
                        r_dv[c]  <= {r_den, 1'b0};
                        r_q[c]   <= '0;
                    end
                    r_rem[3] <= REM_W'({r_den, 1'b0}) + REM_W'(ALPHA_MAX);
                    r_dv[3]  <= DV_W'(ALPHA_DIV);
                    r_q[3]   <= '0;
                    r_zero   <= (r_den == '0);
                end
                default: begin
                    for (int l = 0; l < LANES; l++) begin
                        if (ge[l]) begin
                            r_rem[l]        <= r_rem[l] - shifted[l];
                            r_q[l][bit_i]   <= 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_zero ? '0 : {r_q[3], r_q[2], r_q[1], r_q[0]};

endmodule

// ===== rtl/afc_dpath.sv =====
// Datapath: canvas and save-log memories, frame counters, blend unit, output register.
module afc_dpath import afc_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  s_axis_tvalid,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [ACT_W-1:0]      s_axis_tuser,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tuser
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int LCNT_W = $clog2(DEPTH + 1);
    localparam int LOG_W  = AW + PIX_W;

    logic [PIX_W-1:0] r_canvas [DEPTH];
    logic [LOG_W-1:0] r_log [DEPTH];

    logic [CFG_DATA_W-1:0] r_cw, r_ch;
    logic [ACT_W-1:0]      r_act;
    logic [POS_W-1:0]      r_xp, r_yp;
    logic [SIZE_W-1:0]     r_fw, r_fh;
    logic                  r_bo;
    logic [DM_W-1:0]       r_dm;
    logic [PIX_W-1:0]      r_px;

    logic [POS_W-1:0]   r_rx, r_ry;
    logic [SIZE_W-1:0]  r_rw, r_rh;
    logic               r_bf;
    logic [DM_W-1:0]    r_dk;
    logic [SIZE_W-1:0]  r_col, r_row;
    logic [TAKEN_W-1:0] r_taken;
    logic [LCNT_W-1:0]  r_lcnt, r_ri;
    logic [SIZE_W-1:0]  r_sc, r_sr;
    logic [AW-1:0]      r_ccnt;

    logic [PIX_W-1:0] r_cq;
    logic [LOG_W-1:0] r_lq;
    logic             r_ov;
    logic [PIX_W-1:0] r_od;
    logic             r_oor;

    logic [CMP_W-1:0]   cw_eff, ch_eff;
    logic [CRD_W-1:0]   px_x, px_y, dc_x, dc_y;
    logic               px_in, rd_in, dc_wr, dc_done;
    logic [AW-1:0]      px_addr, rd_addr, dc_addr;
    logic [TAKEN_W-1:0] total;
    logic [SIZE_W:0]    n_col;
    logic               clr_last;
    logic               we, re;
    logic [AW-1:0]      wa, ra;
    logic [PIX_W-1:0]   wd;
    logic               blend_busy;
    logic [PIX_W-1:0]   blend_res;
    logic               in_fire;

    assign in_fire = s_axis_tvalid && i_cmd.ready;

    assign cw_eff = (CMP_W'(r_cw) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : CMP_W'(r_cw);
    assign ch_eff = (CMP_W'(r_ch) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : CMP_W'(r_ch);

    assign px_x    = CRD_W'(r_rx) + CRD_W'(r_col);
    assign px_y    = CRD_W'(r_ry) + CRD_W'(r_row);
    assign px_in   = (CMP_W'(px_x) < cw_eff) && (CMP_W'(px_y) < ch_eff);
    assign px_addr = AW'(int'(px_y) * MAX_SIDE + int'(px_x));
    assign rd_in   = (CMP_W'(r_xp) < cw_eff) && (CMP_W'(r_yp) < ch_eff);
    assign rd_addr = AW'(int'(r_yp) * MAX_SIDE + int'(r_xp));
    assign dc_x    = CRD_W'(r_rx) + CRD_W'(r_sc);
    assign dc_y    = CRD_W'(r_ry) + CRD_W'(r_sr);
    assign dc_done = (r_sr >= r_rh) || (CMP_W'(dc_y) >= ch_eff);
    assign dc_wr   = (r_sc < r_rw) && (CMP_W'(dc_x) < cw_eff);
    assign dc_addr = AW'(int'(dc_y) * MAX_SIDE + int'(dc_x));
    assign total   = TAKEN_W'(r_rw) * TAKEN_W'(r_rh);
    assign n_col   = (SIZE_W + 1)'(r_col) + 1'b1;
    assign clr_last = (r_ccnt == AW'(DEPTH - 1));

    always_comb begin
        we = 1'b0;
        wa = r_ccnt;
        wd = '0;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.dc_step) begin
            we = dc_wr;
            wa = dc_addr;
        end else if (i_cmd.px_write) begin
            we = 1'b1;
            wa = px_addr;
            wd = r_bf ? blend_res : r_px;
        end else if (i_cmd.rs_write) begin
            we = 1'b1;
            wa = r_lq[LOG_W-1:PIX_W];
            wd = r_lq[PIX_W-1:0];
        end
        re = i_cmd.px_read || i_cmd.rd_read;
        ra = i_cmd.px_read ? px_addr : rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_canvas[wa] <= wd;
        end
        if (re) begin
            r_cq <= r_canvas[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.px_log) begin
            r_log[r_lcnt[AW-1:0]] <= {px_addr, r_cq};
        end
        if (i_cmd.rs_read) begin
            r_lq <= r_log[r_ri[AW-1:0]];
        end
    end

    afc_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.px_log && r_bf),
        .i_src    (r_px),
        .i_dst    (r_cq),
        .o_busy   (blend_busy),
        .o_result (blend_res)
    );

    // Hold the beat's fields.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act <= s_axis_tuser;
            r_xp  <= s_axis_tdata[7:0];
            r_yp  <= s_axis_tdata[15:8];
            r_fw  <= s_axis_tdata[24:16];
            r_fh  <= s_axis_tdata[33:25];
            r_bo  <= s_axis_tdata[34];
            r_dm  <= s_axis_tdata[36:35];
            r_px  <= s_axis_tdata[68:37];
        end
        if (i_cmd.out_load) begin
            r_od  <= rd_in ? r_cq : '0;
            r_oor <= !rd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw    <= CFG_DATA_W'(CFG_SIDE_RST);
            r_ch    <= CFG_DATA_W'(CFG_SIDE_RST);
            r_rx    <= '0;
            r_ry    <= '0;
            r_rw    <= '0;
            r_rh    <= '0;
            r_bf    <= 1'b0;
            r_dk    <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_taken <= '0;
            r_lcnt  <= '0;
            r_ri    <= '0;
            r_sc    <= '0;
            r_sr    <= '0;
            r_ccnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_cw <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEIGHT) begin
                    r_ch <= i_cfg_data;
                end
            end
            if (i_cmd.clr_step) begin
                r_ccnt <= clr_last ? '0 : r_ccnt + 1'b1;
            end
            if (i_cmd.begin_frame) begin
                r_rx    <= r_xp;
                r_ry    <= r_yp;
                r_rw    <= r_fw;
                r_rh    <= r_fh;
                r_bf    <= r_bo;
                r_dk    <= r_dm;
                r_col   <= '0;
                r_row   <= '0;
                r_taken <= '0;
                r_lcnt  <= '0;
            end
            if (i_cmd.px_log) begin
                r_lcnt <= r_lcnt + 1'b1;
            end
            if (i_cmd.px_write || i_cmd.px_skip) begin
                r_taken <= r_taken + 1'b1;
                if (n_col >= (SIZE_W + 1)'(r_rw)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= n_col[SIZE_W-1:0];
                end
            end
            if (i_cmd.dc_step) begin
                if (dc_wr) begin
                    r_sc <= r_sc + 1'b1;
                end else begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                end
            end
            if (i_cmd.rs_write) begin
                r_ri <= r_ri + 1'b1;
            end
            if (i_cmd.close) begin
                r_rw    <= '0;
                r_rh    <= '0;
                r_bf    <= 1'b0;
                r_dk    <= '0;
                r_col   <= '0;
                r_row   <= '0;
                r_taken <= '0;
                r_lcnt  <= '0;
                r_ri    <= '0;
                r_sc    <= '0;
                r_sr    <= '0;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.in_valid   = s_axis_tvalid;
        o_sts.act        = r_act;
        o_sts.dispose    = r_dk;
        o_sts.blend      = r_bf;
        o_sts.px_take    = r_taken < total;
        o_sts.px_in      = px_in;
        o_sts.clr_last   = clr_last;
        o_sts.dc_done    = dc_done;
        o_sts.rs_done    = (r_ri == r_lcnt);
        o_sts.blend_busy = blend_busy;
        o_sts.out_full   = r_ov;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_oor;

`ifndef SYNTHESIS
    a_log_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= LCNT_W'(DEPTH))
        else $error("save log count past depth");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_ov)
        else $error("output register overwritten");
    a_blend_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.px_write && r_bf) |-> !blend_busy)
        else $error("pixel written before blend finished");
    a_restore_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rs_read |-> (r_ri < r_lcnt))
        else $error("restore read past save log");
`endif

endmodule

// ===== rtl/afc_ctrl.sv =====
// Controller state machine: sequences clears, pixel updates, reads and disposal.
module afc_ctrl import afc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_sts.in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_sts.act)
                    ACT_CLEAR: n_state = ST_CLR;
                    ACT_PIXEL: n_state = (i_sts.px_take && i_sts.px_in) ? ST_PX_RD : ST_IDLE;
                    ACT_END: begin
                        if (i_sts.dispose == DISP_CLEAR) begin
                            n_state = ST_DCLR;
                        end else if (i_sts.dispose == DISP_RESTORE) begin
                            n_state = ST_RS_RD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    ACT_READ: n_state = ST_RD_RD;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_PX_RD:    n_state = ST_PX_LOG;
            ST_PX_LOG:   n_state = i_sts.blend ? ST_PX_BLEND : ST_PX_WR;
            ST_PX_BLEND: begin
                if (!i_sts.blend_busy) n_state = ST_PX_WR;
            end
            ST_PX_WR:    n_state = ST_IDLE;
            ST_RD_RD:    n_state = ST_RD_OUT;
            ST_RD_OUT: begin
                if (!i_sts.out_full) n_state = ST_IDLE;
            end
            ST_DCLR: begin
                if (i_sts.dc_done) n_state = ST_IDLE;
            end
            ST_RS_RD:    n_state = i_sts.rs_done ? ST_IDLE : ST_RS_WR;
            ST_RS_WR:    n_state = ST_RS_RD;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLR:  o_cmd.clr_step = 1'b1;
            ST_IDLE: o_cmd.ready = 1'b1;
            ST_DECODE: begin
                case (i_sts.act)
                    ACT_BEGIN: o_cmd.begin_frame = 1'b1;
                    ACT_PIXEL: o_cmd.px_skip = i_sts.px_take && !i_sts.px_in;
                    ACT_END: begin
                        o_cmd.close = (i_sts.dispose != DISP_CLEAR)
                                   && (i_sts.dispose != DISP_RESTORE);
                    end
                    default: o_cmd.close = 1'b0;
                endcase
            end
            ST_PX_RD:  o_cmd.px_read = 1'b1;
            ST_PX_LOG: o_cmd.px_log = 1'b1;
            ST_PX_WR:  o_cmd.px_write = 1'b1;
            ST_RD_RD:  o_cmd.rd_read = 1'b1;
            ST_RD_OUT: o_cmd.out_load = !i_sts.out_full;
            ST_DCLR: begin
                o_cmd.close   = i_sts.dc_done;
                o_cmd.dc_step = !i_sts.dc_done;
            end
            ST_RS_RD: begin
                o_cmd.close   = i_sts.rs_done;
                o_cmd.rs_read = !i_sts.rs_done;
            end
            ST_RS_WR:  o_cmd.rs_write = 1'b1;
            default:   o_cmd.ready = 1'b0;
        endcase
    end

endmodule

// ===== rtl/animated_frame_compositor.sv =====
// Top level of the animated frame compositor: controller plus datapath.
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  tdata commands, tuser action
//  m_axis    out   m_axis_tvalid / m_axis_tready  tdata pixel_out, tuser out_of_range
//  cfg       in    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each beat passes through an idle and a decode state before its work; a pixel is
// read, logged, blended if asked (waiting while the blend unit is busy) and written,
// a read is fetched and loaded into the output register, and a canvas clear runs a clearing pass.
// End of frame: clear region writes each cleared pixel in turn, row by row inside
// the canvas; restore reads and writes back each saved pixel in turn.
// After reset a clearing pass over the whole canvas runs with no beat taken.
// Config writes are always taken; a read result waits in the output register.
module animated_frame_compositor import afc_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_pos[7:0] y_pos[15:8] frame_width[24:16] frame_height[33:25]
    // blend_over[34] dispose_mode[36:35] pixel[68:37] zero[71:69]
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // action[2:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out[31:0]
    output logic [PIX_W-1:0]      m_axis_tdata,
    // out_of_range[0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign s_axis_tready = cmd.ready;
    assign o_cfg_ready   = 1'b1;

    afc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    afc_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the animated frame compositor.
`timescale 1ns / 1ps

module tb;
    import afc_pkg::*;

    localparam int SIDE = MAX_SIDE_DEF;
    localparam int DEPTH = SIDE * SIDE;
    localparam logic [DM_W-1:0] DISP_KEEP = 2'd0;
    localparam logic [DM_W-1:0] DISP_ODD = 2'd3;
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  xp;
        logic [POS_W-1:0]  yp;
        logic [SIZE_W-1:0] fw;
        logic [SIZE_W-1:0] fh;
        logic              blend;
        logic [DM_W-1:0]   dm;
        logic [PIX_W-1:0]  pix;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             oor;
    } t_read;

    class canvas_sb;
        logic [PIX_W-1:0] canvas [DEPTH];
        logic [PIX_W-1:0] backup [DEPTH];
        bit               marked [DEPTH];
        int               saved_idx[$];
        t_read            reads_due[$];
        int               cw, ch;
        int               rx, ry, rw, rh, col, row, taken;
        bit               rblend;
        logic [DM_W-1:0]  rdisp;
        int               errors;
        int               reads_seen;

        function void init();
            for (int i = 0; i < DEPTH; i++) begin
                canvas[i] = '0;
                marked[i] = 0;
            end
            cw = SIDE;
            ch = SIDE;
            rx = 0;
            ry = 0;
            close_region();
        endfunction

        function void close_region();
            rw = 0;
            rh = 0;
            rblend = 0;
            rdisp = DISP_KEEP;
            col = 0;
            row = 0;
            taken = 0;
        endfunction

        function void drop_saves();
            foreach (saved_idx[k]) marked[saved_idx[k]] = 0;
            saved_idx.delete();
        endfunction

        function void set_side(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            int s;
            s = (v > SIDE) ? SIDE : int'(v);
            if (idx == CFG_WIDTH) cw = s;
            else if (idx == CFG_HEIGHT) ch = s;
        endfunction

        function logic [PIX_W-1:0] over(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
            longint unsigned a, d, den, s, t, num;
            logic [PIX_W-1:0] res;
            a = src[31:24];
            d = dst[31:24];
            den = a * 255 + d * (255 - a);
            if (den == 0) return '0;
            for (int c = 0; c < 3; c++) begin
                s = (src >> (8 * c)) & 8'hFF;
                t = (dst >> (8 * c)) & 8'hFF;
                num = s * a * 255 + t * d * (255 - a);
                res[8*c +: 8] = 8'((2 * num + den) / (2 * den));
            end
            res[31:24] = 8'((2 * den + 255) / 510);
            return res;
        endfunction

        function void note_input(t_item it);
            int x, y, idx;
            t_read r;
            case (it.act)
                ACT_CLEAR: for (int i = 0; i < DEPTH; i++) canvas[i] = '0;
                ACT_BEGIN: begin
                    close_region();
                    drop_saves();
                    rx = it.xp;
                    ry = it.yp;
                    rw = it.fw;
                    rh = it.fh;
                    rblend = it.blend;
                    rdisp = it.dm;
                end
                ACT_PIXEL: if (taken < rw * rh) begin
                    x = rx + col;
                    y = ry + row;
                    if (x < cw && y < ch) begin
                        idx = y * SIDE + x;
                        backup[idx] = canvas[idx];
                        if (!marked[idx]) begin
                            marked[idx] = 1;
                            saved_idx.insert(saved_idx.size(), idx);
                        end
                        canvas[idx] = rblend ? over(it.pix, canvas[idx]) : it.pix;
                    end
                    taken++;
                    col++;
                    if (col >= rw) begin
                        col = 0;
                        row++;
                    end
                end
                ACT_END: begin
                    if (rdisp == DISP_CLEAR) begin
                        for (int r2 = 0; r2 < rh && ry + r2 < ch; r2++)
                            for (int c2 = 0; c2 < rw && rx + c2 < cw; c2++)
                                canvas[(ry + r2) * SIDE + rx + c2] = '0;
                    end else if (rdisp == DISP_RESTORE) begin
                        foreach (saved_idx[k]) canvas[saved_idx[k]] = backup[saved_idx[k]];
                    end
                    drop_saves();
                    close_region();
                end
                ACT_READ: begin
                    if (it.xp < cw && it.yp < ch) begin
                        r.pix = canvas[it.yp * SIDE + it.xp];
                        r.oor = 0;
                    end else begin
                        r.pix = '0;
                        r.oor = 1;
                    end
                    reads_due.insert(reads_due.size(), r);
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [PIX_W-1:0] pix, logic oor);
            t_read w;
            reads_seen++;
            if (reads_due.size() == 0) begin
                report("unexpected read beat", pix, '0);
                return;
            end
            w = reads_due.pop_front();
            if (pix !== w.pix) report("pixel_out", pix, w.pix);
            if (oor !== w.oor) report("out_of_range", PIX_W'(oor), PIX_W'(w.oor));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [ACT_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    animated_frame_compositor u_top (.*);

    canvas_sb sb;
    bit       hold_req;
    int       sent;
    int       frames;
    int       clears_left;

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("animated_frame_compositor verification failed");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int n;
        m_axis_tready = 0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 0;
                    repeat (n) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function t_item mk(logic [ACT_W-1:0] a, int x, int y, int w, int h, bit b,
                       logic [DM_W-1:0] d, logic [PIX_W-1:0] p);
        t_item c;
        c.act = a;
        c.xp = POS_W'(x);
        c.yp = POS_W'(y);
        c.fw = SIZE_W'(w);
        c.fh = SIZE_W'(h);
        c.blend = b;
        c.dm = d;
        c.pix = p;
        return c;
    endfunction

    task send(t_item it);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= it.act;
        s_axis_tdata <= {3'b0, it.pix, it.dm, it.blend, it.fh, it.fw, it.yp, it.xp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(it);
        sent++;
        if (it.act == ACT_BEGIN) frames++;
    endtask

    task rd(int x, int y);
        send(mk(ACT_READ, x, y, 0, 0, 0, DISP_KEEP, $urandom));
    endtask

    task px(logic [PIX_W-1:0] p);
        send(mk(ACT_PIXEL, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                DM_W'($urandom), p));
    endtask

    task drain();
        s_axis_tvalid <= 0;
        while (sb.reads_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.set_side(idx, v);
        @(posedge i_clk);
    endtask

    task rand_frame();
        int w, h, x, y, np, r;
        r = $urandom_range(0, 99);
        if (r < 3 && clears_left > 0) begin
            clears_left--;
            send(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                    DM_W'($urandom), $urandom));
            return;
        end
        if (r < 7) begin
            send(mk(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom, $urandom,
                    $urandom, $urandom, 1'($urandom), DM_W'($urandom), $urandom));
            return;
        end
        if (r < 10) begin
            if ($urandom_range(0, 1)) px($urandom);
            else send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
            return;
        end
        r = $urandom_range(0, 9);
        w = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 16) : (r == 2) ? SIDE
            : $urandom_range(1, 6);
        h = (w == SIDE) ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0) ? 0
            : $urandom_range(1, 5);
        if ($urandom_range(0, 1)) begin
            x = sb.cw - $urandom_range(0, 3);
            y = sb.ch - $urandom_range(0, 3);
            x = (x < 0) ? 0 : (x > 255) ? 255 : x;
            y = (y < 0) ? 0 : (y > 255) ? 255 : y;
        end else begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
        end
        send(mk(ACT_BEGIN, x, y, w, h, $urandom_range(0, 2) != 0,
                DM_W'($urandom_range(0, 3)), 0));
        np = w * h;
        if (np > 24) np = $urandom_range(3, 24);
        r = $urandom_range(0, 9);
        if (r == 0) np += $urandom_range(1, 2);
        else if (r == 1 && np > 0) np -= 1;
        for (int i = 0; i < np; i++) begin
            if ($urandom_range(0, 3) == 0) px({8'($urandom_range(0, 3) == 0 ? 0 : 255),
                                               24'($urandom)});
            else px($urandom);
            if ($urandom_range(0, 4) == 0) rd(x + $urandom_range(0, w), y + $urandom_range(0, h));
        end
        if ($urandom_range(0, 9) != 0) send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0) rd($urandom, $urandom);
            else rd(x + $urandom_range(0, w), y + $urandom_range(0, h));
        end
    endtask

    int side_w[7] = '{256, 511, 1, 0, 40, 300, 200};
    int side_h[7] = '{256, 511, 1, 5, 17, 0, 256};

    initial begin
        sb = new();
        sb.init();
        clears_left = 4;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // hold config until the reset clearing pass is over
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        write_cfg(CFG_WIDTH, 9'd256);
        write_cfg(CFG_HEIGHT, 9'd256);

        // frame clipped at the corner, restored on close
        rd(0, 0);
        rd(255, 255);
        send(mk(ACT_BEGIN, 254, 254, 4, 2, 0, DISP_RESTORE, 0));
        px(32'hFFFF_FFFF);
        px(32'h8040_2010);
        px(32'h0000_0000);
        px(32'h1234_5678);
        px(32'hFF00_FF00);
        px(32'h00FF_00FF);
        rd(255, 255);
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        rd(255, 255);
        // replace then blend over, clear region on close
        send(mk(ACT_BEGIN, 0, 0, 3, 1, 0, DISP_KEEP, 0));
        px(32'h8020_4060);
        px(32'h0000_0000);
        px(32'hFFAB_CDEF);
        send(mk(ACT_BEGIN, 0, 0, 3, 1, 1, DISP_CLEAR, 0));
        px(32'h80FF_0000);
        px(32'h0011_2233);
        px(32'hFF01_0203);
        px(32'hFFFF_FFFF);
        rd(0, 0);
        rd(1, 0);
        rd(2, 0);
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        rd(0, 0);
        // empty frames, odd disposal, spare action, wide clipped clear
        send(mk(ACT_BEGIN, 5, 5, 0, 256, 1, DISP_CLEAR, 0));
        px(32'hFFFF_FFFF);
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        send(mk(ACT_BEGIN, 0, 0, 256, 0, 0, DISP_ODD, 0));
        send(mk(ACT_SPARE_HI, 255, 255, 511, 511, 1, DISP_ODD, 32'hFFFF_FFFF));
        send(mk(ACT_BEGIN, 100, 9, 256, 1, 0, DISP_ODD, 0));
        px(32'hDEAD_BEEF);
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        send(mk(ACT_BEGIN, 200, 9, 256, 256, 0, DISP_CLEAR, 0));
        px(32'hCAFE_F00D);
        send(mk(ACT_END, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        rd(100, 9);
        send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, DISP_KEEP, 0));
        // stall the result side while reads pile up
        hold_req = 1;
        for (int i = 0; i < 12; i++) rd(i, 0);
        drain();

        foreach (side_w[p]) begin
            write_cfg(CFG_WIDTH, CFG_DATA_W'(side_w[p]));
            write_cfg(CFG_HEIGHT, CFG_DATA_W'(side_h[p]));
            for (int n = sent + 85; sent < n;) rand_frame();
            rd($urandom, $urandom);
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Run covered %0d input beats, %0d frames and %0d canvas reads over 7 sizes.",
                 sent, frames, sb.reads_seen);
        if (sb.errors == 0 && sb.reads_due.size() == 0) begin
            $display("animated_frame_compositor verification clean");
        end else begin
            $display("%0d mismatches, %0d reads never returned", sb.errors, sb.reads_due.size());
            $display("animated_frame_compositor verification failed");
        end
        $finish;
    end

endmodule
